// ----- src/ws2_pkg.sv -----
// Shared types and constants of the WS2812 pixel bit encoder.
`default_nettype none

package ws2_pkg;

    localparam int COLOUR_BITS = 8;
    localparam int WORD_BITS   = 3 * COLOUR_BITS;
    localparam int HIGH_W      = 10;
    localparam int LOW_W       = 16;
    localparam int IDX_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Symbol index of the last data bit and of the latch gap
    localparam logic [IDX_W-1:0] LAST_DATA_IDX = IDX_W'(WORD_BITS - 1);
    localparam logic [IDX_W-1:0] LATCH_IDX     = IDX_W'(WORD_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

    // Reset values of the timing registers
    localparam logic [HIGH_W-1:0] RST_ZERO_HIGH = 10'd20;
    localparam logic [HIGH_W-1:0] RST_ZERO_LOW  = 10'd43;
    localparam logic [HIGH_W-1:0] RST_ONE_HIGH  = 10'd40;
    localparam logic [HIGH_W-1:0] RST_ONE_LOW   = 10'd22;
    localparam logic [LOW_W-1:0]  RST_LATCH     = 16'd2500;

    typedef struct packed {
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] blue;
        logic                   end_of_frame;
    } pixel_t;

    typedef struct packed {
        logic              bit_value;
        logic [HIGH_W-1:0] high_cycles;
        logic [LOW_W-1:0]  low_cycles;
        logic              is_latch_gap;
        logic              last;
    } symbol_t;

    // Classified pixel: bits in line order and index of its final symbol
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [IDX_W-1:0]     final_idx;
    } job_t;

    typedef struct packed {
        logic [HIGH_W-1:0] zero_high;
        logic [HIGH_W-1:0] zero_low;
        logic [HIGH_W-1:0] one_high;
        logic [HIGH_W-1:0] one_low;
        logic [LOW_W-1:0]  latch;
    } timing_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

// ----- src/ws2_cfg.sv -----
// Timing configuration registers of the WS2812 encoder.
`default_nettype none

module ws2_cfg (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               wr_en,
    input  wire [ws2_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire [ws2_pkg::CFG_DATA_W-1:0]     wr_data,
    output ws2_pkg::timing_t                  timing
);

    ws2_pkg::timing_t timing_reg;
    ws2_pkg::timing_t timing_next;

    // Decode the write; unknown indexes are dropped
    always_comb
    begin
        timing_next = timing_reg;
        if (wr_en)
        begin
            case (wr_index)
                ws2_pkg::CFG_ZERO_HIGH: timing_next.zero_high = wr_data[ws2_pkg::HIGH_W-1:0];
                ws2_pkg::CFG_ZERO_LOW:  timing_next.zero_low  = wr_data[ws2_pkg::HIGH_W-1:0];
                ws2_pkg::CFG_ONE_HIGH:  timing_next.one_high  = wr_data[ws2_pkg::HIGH_W-1:0];
                ws2_pkg::CFG_ONE_LOW:   timing_next.one_low   = wr_data[ws2_pkg::HIGH_W-1:0];
                ws2_pkg::CFG_LATCH:     timing_next.latch     = wr_data[ws2_pkg::LOW_W-1:0];
                default:                timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.zero_high <= ws2_pkg::RST_ZERO_HIGH;
            timing_reg.zero_low  <= ws2_pkg::RST_ZERO_LOW;
            timing_reg.one_high  <= ws2_pkg::RST_ONE_HIGH;
            timing_reg.one_low   <= ws2_pkg::RST_ONE_LOW;
            timing_reg.latch     <= ws2_pkg::RST_LATCH;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

`default_nettype wire

// ----- src/ws2_front.sv -----
// Front stage: accepts pixels and turns them into line-order jobs.
`default_nettype none

module ws2_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  ws2_pkg::pixel_t     in_pixel,
    input  ws2_pkg::queue_stat_t q_stat,
    output logic                push,
    output ws2_pkg::job_t       push_job
);

    logic          valid_reg;
    logic          valid_next;
    ws2_pkg::job_t job_reg;
    ws2_pkg::job_t job_next;
    logic          accept;

    assign in_stall = valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_stat.full;

    // Classify: pack colors in green, red, blue order, pick final symbol
    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next     = 1'b1;
            job_next.word  = {in_pixel.green, in_pixel.red, in_pixel.blue};
            job_next.final_idx = in_pixel.end_of_frame ? ws2_pkg::LATCH_IDX
                                                       : ws2_pkg::LAST_DATA_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign push_job = job_reg;

endmodule

`default_nettype wire

// ----- src/ws2_queue.sv -----
// Two-entry job queue between front and back stages.
`default_nettype none

module ws2_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  ws2_pkg::job_t         push_job,
    input  wire                   pop,
    output ws2_pkg::job_t         pop_job,
    output ws2_pkg::queue_stat_t  stat
);

    ws2_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- src/ws2_back.sv -----
// Back stage: serializes a job into line symbols, one per cycle while the receiver does not stall.
`default_nettype none

module ws2_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ws2_pkg::timing_t      timing,
    input  ws2_pkg::queue_stat_t  q_stat,
    input  ws2_pkg::job_t         pop_job,
    output logic                  pop,
    output logic                  out_valid,
    input  wire                   out_stall,
    output ws2_pkg::symbol_t      out_symbol
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [ws2_pkg::WORD_BITS-1:0] shift_reg;
    logic [ws2_pkg::WORD_BITS-1:0] shift_next;
    logic [ws2_pkg::IDX_W-1:0]     cnt_reg;
    logic [ws2_pkg::IDX_W-1:0]     cnt_next;
    logic [ws2_pkg::IDX_W-1:0]     final_reg;
    logic [ws2_pkg::IDX_W-1:0]     final_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ws2_pkg::symbol_t              sym_reg;
    ws2_pkg::symbol_t              sym_next;
    logic                          load_ok;
    logic                          emit;
    logic                          finishing;

    assign load_ok   = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && load_ok;
    assign finishing = emit && (cnt_reg == final_reg);
    assign pop       = !q_stat.empty && (!busy_reg || finishing);

    // Build the next symbol, advance the bit counter, reload on pop
    always_comb
    begin
        busy_next      = busy_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        sym_next       = sym_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (cnt_reg == ws2_pkg::LATCH_IDX)
            begin
                sym_next.bit_value    = 1'b0;
                sym_next.high_cycles  = '0;
                sym_next.low_cycles   = timing.latch;
                sym_next.is_latch_gap = 1'b1;
                sym_next.last         = 1'b1;
            end
            else
            begin
                sym_next.bit_value    = shift_reg[ws2_pkg::WORD_BITS-1];
                sym_next.high_cycles  = shift_reg[ws2_pkg::WORD_BITS-1] ? timing.one_high
                                                                         : timing.zero_high;
                sym_next.low_cycles   = ws2_pkg::LOW_W'(shift_reg[ws2_pkg::WORD_BITS-1]
                                                        ? timing.one_low : timing.zero_low);
                sym_next.is_latch_gap = 1'b0;
                sym_next.last         = (cnt_reg == final_reg);
            end
            shift_next = {shift_reg[ws2_pkg::WORD_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + ws2_pkg::IDX_W'(1);
        end
        else if (load_ok)
        begin
            out_valid_next = 1'b0;
        end

        if (finishing)
        begin
            busy_next = 1'b0;
        end
        if (pop)
        begin
            busy_next  = 1'b1;
            shift_next = pop_job.word;
            final_next = pop_job.final_idx;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        final_reg <= final_next;
        sym_reg   <= sym_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = sym_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= final_reg))
        else $error("symbol counter ran past final symbol");

    a_final_legal: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (final_reg == ws2_pkg::LAST_DATA_IDX || final_reg == ws2_pkg::LATCH_IDX))
        else $error("bad final symbol index");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && busy_reg) |=> $stable(cnt_reg))
        else $error("counter advanced under output stall");

    a_gap_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cnt_reg == ws2_pkg::LATCH_IDX) |-> finishing)
        else $error("latch gap not the final symbol");

endmodule

`default_nettype wire

// ----- src/ws2812_pixel_bit_encoder_top.sv -----
// WS2812 pixel bit encoder: top level.
//
// Input channel (in_valid / in_stall / in_pixel): one pixel item per
// handshake, taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_symbol): one line symbol per
// handshake; 24 data symbols (green, red, blue, MSB first), plus a latch gap
// symbol when end_of_frame is set. last marks the final symbol of a pixel.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): timing
// registers, to be written by the user only while the encoder is idle, which the
// block does not enforce; cfg_ready is always high and unknown indexes are ignored.
// A pixel passes the front job register, the queue entry and the serializer's
// shift register before its first symbol is registered at the output.
// Throughput: one symbol per cycle while the receiver does not stall.
// A two-entry job queue lets the next pixels be accepted while one is
// being serialized.
// Reset clears the pipeline and loads the default timings. When the receiver
// stalls, the pending symbol holds and the serializer stops; the front keeps
// accepting until the queue fills, then raises in_stall.
`default_nettype none

module ws2812_pixel_bit_encoder_top (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  ws2_pkg::pixel_t                    in_pixel,
    output logic                               out_valid,
    input  wire                                out_stall,
    output ws2_pkg::symbol_t                   out_symbol,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [ws2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [ws2_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ws2_pkg::timing_t     timing;
    ws2_pkg::queue_stat_t q_stat;
    ws2_pkg::job_t        push_job;
    ws2_pkg::job_t        pop_job;
    logic                 push;
    logic                 pop;

    assign cfg_ready = 1'b1;

    ws2_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing)
    );

    ws2_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_pixel (in_pixel),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    ws2_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    ws2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .q_stat     (q_stat),
        .pop_job    (pop_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_symbol (out_symbol)
    );

endmodule

`default_nettype wire
